// File: hdl/assert_macros.svh
// Assertion macros used by the tracer top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define FLCT_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// An implication checked in the same cycle.
`define FLCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An implication whose consequent is checked in the next cycle.
`define FLCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FLCT_ASSERT(lbl, clk, rst_n, cond)
`define FLCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define FLCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/flct_pkg.sv
package flct_pkg;

    // Grid and coordinate sizes.
    localparam int GRID_SIZE  = 16;
    localparam int COORD_W    = 4;
    localparam int CFG_DATA_W = 4;
    // Bresenham error term: holds -30 .. +30.
    localparam int D_W        = 7;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [D_W-1:0]     t_err;

    // Fixed-axis selector codes.
    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    // Configuration register indexes.
    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_TRACE_AXIS = 1'b0;
    localparam t_cfg_idx CFG_AXIS_POS   = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAIN,
        ST_PREV,
        ST_NEXT
    } t_flct_state;

    // Which cell the datapath forms for the current key.
    typedef enum logic [1:0] {
        CELL_MAIN,
        CELL_PREV,
        CELL_NEXT
    } t_flct_cell;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       emit;
        t_flct_cell cell_sel;
        logic       step;
        logic       advance;
        logic       last;
    } t_flct_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic d_pos;
        logic at_end;
        logic below_grid;
    } t_flct_stat;

endpackage

// File: hdl/flct_if.sv
// Line channel: one item is a pair of tile endpoints.
interface flct_in_if;
    logic                        valid;
    logic                        ready;
    logic [flct_pkg::COORD_W-1:0] start_u;
    logic [flct_pkg::COORD_W-1:0] start_v;
    logic [flct_pkg::COORD_W-1:0] end_u;
    logic [flct_pkg::COORD_W-1:0] end_v;

    modport source (output valid, start_u, start_v, end_u, end_v, input ready);
    modport sink   (input valid, start_u, start_v, end_u, end_v, output ready);
endinterface

// Key channel: one item is a 3D cell key.
interface flct_out_if;
    logic                        valid;
    logic                        ready;
    logic [flct_pkg::COORD_W-1:0] key_a;
    logic [flct_pkg::COORD_W-1:0] key_b;
    logic [flct_pkg::COORD_W-1:0] key_c;
    logic                        final_cell;

    modport source (output valid, key_a, key_b, key_c, final_cell, input ready);
    modport sink   (input valid, key_a, key_b, key_c, final_cell, output ready);
endinterface

// File: hdl/fattened_line_cell_tracer_unit.sv
// Thickened line cell tracer.
// i_line takes one item per line: two 4-bit tile endpoints (start_u/v, end_u/v).
// o_key gives one item per 3D cell key of the line, in walk order, the fixed
// coordinate inserted on the axis set by configuration register 0 (trace_axis)
// and taken from register 1 (axis_position). The last key of a line carries
// final_cell. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data,
// by the user only while no line is in flight; the block does not enforce it.
// The idle state loads an accepted line into the walk registers; the main state
// then forms the first key into the output register once that register is free.
// After that the walker forms one key per cycle while the output register can
// take it. A line gives 1 to 46 keys, and no new line is taken until the last.
// A new line is accepted in the cycle after the last key is formed, even while
// that key still waits in the output.
// When the receiver holds ready low, the walker stops with the key held in the
// output register and resumes when it is taken; no key is lost or repeated.
// Synchronous reset clears the controller, the output valid flag and both
// configuration registers (axis x, position 0); no clearing pass is needed.
`include "assert_macros.svh"

module fattened_line_cell_tracer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    flct_in_if.sink                         i_line,
    flct_out_if.source                      o_key,
    input  logic                            i_cfg_we,
    input  flct_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [flct_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import flct_pkg::*;

    t_flct_cmd  w_cmd;
    t_flct_stat w_stat;
    logic       w_in_ready;

    // Sequencer.
    flct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_line.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_line.ready = w_in_ready;

    // Line walker and output register.
    flct_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start_u    (i_line.start_u),
        .i_start_v    (i_line.start_v),
        .i_end_u      (i_line.end_u),
        .i_end_v      (i_line.end_v),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_key.valid),
        .i_out_ready  (o_key.ready),
        .o_key_a      (o_key.key_a),
        .o_key_b      (o_key.key_b),
        .o_key_c      (o_key.key_c),
        .o_final_cell (o_key.final_cell)
    );

    // No key is formed while the block waits for a line.
    `FLCT_ASSERT(a_idle_no_emit, i_clk, i_rst_n, !(w_in_ready && w_cmd.emit))
    // The last key of a line returns the block to accepting lines.
    `FLCT_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, w_cmd.emit && w_cmd.last, w_in_ready)
    // The major axis never advances past the end of the line.
    `FLCT_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, w_cmd.advance, !w_stat.at_end)
    // A key is formed only when the output register can take it.
    `FLCT_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, w_cmd.emit, w_stat.out_free)

endmodule

// File: hdl/flct_ctrl.sv
module flct_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  flct_pkg::t_flct_stat   i_stat,
    output flct_pkg::t_flct_cmd    o_cmd
);
    import flct_pkg::*;

    t_flct_state r_state;
    t_flct_state n_state;
    logic        w_extra;

    // Extra cells follow a main cell when the minor axis moves before the end.
    assign w_extra = i_stat.d_pos && !i_stat.at_end;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MAIN;
                end
            end
            ST_MAIN: begin
                if (i_stat.out_free) begin
                    if (w_extra) begin
                        n_state = ST_PREV;
                    end else if (i_stat.at_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PREV: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.below_grid ? ST_NEXT : ST_MAIN;
                end
            end
            ST_NEXT: begin
                if (i_stat.out_free) begin
                    n_state = ST_MAIN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands.
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.cell_sel = CELL_MAIN;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MAIN: begin
                o_cmd.emit     = i_stat.out_free;
                o_cmd.cell_sel = CELL_MAIN;
                o_cmd.step     = i_stat.out_free;
                o_cmd.last     = i_stat.at_end;
                o_cmd.advance  = i_stat.out_free && !w_extra && !i_stat.at_end;
            end
            ST_PREV: begin
                o_cmd.emit     = i_stat.out_free;
                o_cmd.cell_sel = CELL_PREV;
                o_cmd.advance  = i_stat.out_free && !i_stat.below_grid;
            end
            ST_NEXT: begin
                o_cmd.emit     = i_stat.out_free;
                o_cmd.cell_sel = CELL_NEXT;
                o_cmd.advance  = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/flct_dp.sv
module flct_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  flct_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [flct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  flct_pkg::t_coord              i_start_u,
    input  flct_pkg::t_coord              i_start_v,
    input  flct_pkg::t_coord              i_end_u,
    input  flct_pkg::t_coord              i_end_v,
    input  flct_pkg::t_flct_cmd           i_cmd,
    output flct_pkg::t_flct_stat          o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output flct_pkg::t_coord              o_key_a,
    output flct_pkg::t_coord              o_key_b,
    output flct_pkg::t_coord              o_key_c,
    output logic                          o_final_cell
);
    import flct_pkg::*;

    // Configuration.
    t_axis  r_trace_axis;
    t_coord r_axis_pos;

    // Walk state.
    t_coord r_major;
    t_coord r_end;
    t_coord r_minor;
    t_coord r_old_minor;
    t_coord r_prev;
    t_coord r_da;
    t_coord r_db;
    t_err   r_d;
    logic   r_step_neg;
    logic   r_steep;

    // Output register.
    logic   r_out_valid;
    t_coord r_key_a;
    t_coord r_key_b;
    t_coord r_key_c;
    logic   r_final;

    // Setup of a new line.
    t_coord w_adu;
    t_coord w_adv;
    logic   w_steep;
    t_coord w_a0s;
    t_coord w_a1s;
    t_coord w_b0s;
    t_coord w_b1s;
    logic   w_swap;
    t_coord w_a0;
    t_coord w_a1;
    t_coord w_b0;
    t_coord w_b1;
    t_coord w_da;
    t_coord w_db;
    t_err   w_d0;

    // Key formation.
    t_coord w_cmaj;
    t_coord w_cmin;
    t_coord w_u;
    t_coord w_v;
    t_coord w_ka;
    t_coord w_kb;
    t_coord w_kc;

    // Octant choice and endpoint ordering.
    always_comb begin
        w_adu   = (i_end_u >= i_start_u) ? i_end_u - i_start_u : i_start_u - i_end_u;
        w_adv   = (i_end_v >= i_start_v) ? i_end_v - i_start_v : i_start_v - i_end_v;
        w_steep = !(w_adv < w_adu);
        w_a0s   = w_steep ? i_start_v : i_start_u;
        w_a1s   = w_steep ? i_end_v   : i_end_u;
        w_b0s   = w_steep ? i_start_u : i_start_v;
        w_b1s   = w_steep ? i_end_u   : i_end_v;
        w_swap  = w_a0s > w_a1s;
        w_a0    = w_swap ? w_a1s : w_a0s;
        w_a1    = w_swap ? w_a0s : w_a1s;
        w_b0    = w_swap ? w_b1s : w_b0s;
        w_b1    = w_swap ? w_b0s : w_b1s;
        w_da    = w_a1 - w_a0;
        w_db    = (w_b1 >= w_b0) ? w_b1 - w_b0 : w_b0 - w_b1;
        w_d0    = {2'b00, w_db, 1'b0} - {3'b000, w_da};
    end

    // Status toward the controller.
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.d_pos      = !r_d[D_W-1] && (r_d != '0);
    assign o_stat.at_end     = r_major == r_end;
    assign o_stat.below_grid = {1'b0, r_major} < (COORD_W+1)'(GRID_SIZE - 1);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_axis <= AXIS_X;
            r_axis_pos   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRACE_AXIS: r_trace_axis <= i_cfg_data[1:0];
                CFG_AXIS_POS:   r_axis_pos   <= i_cfg_data[COORD_W-1:0];
                default:        r_axis_pos   <= r_axis_pos;
            endcase
        end
    end

    // Walk registers: load a line, step the error term, advance the major axis.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_major    <= w_a0;
            r_end      <= w_a1;
            r_minor    <= w_b0;
            r_prev     <= w_a0;
            r_da       <= w_da;
            r_db       <= w_db;
            r_d        <= w_d0;
            r_step_neg <= w_b1 < w_b0;
            r_steep    <= w_steep;
        end else begin
            if (i_cmd.step) begin
                if (o_stat.d_pos) begin
                    r_old_minor <= r_minor;
                    r_minor     <= r_step_neg ? r_minor - 1'b1 : r_minor + 1'b1;
                    r_d         <= r_d + {2'b00, r_db, 1'b0} - {2'b00, r_da, 1'b0};
                end else begin
                    r_d         <= r_d + {2'b00, r_db, 1'b0};
                end
            end
            if (i_cmd.advance) begin
                r_prev  <= r_major;
                r_major <= r_major + 1'b1;
            end
        end
    end

    // Cell of the current key in (major, minor), then in (u, v).
    always_comb begin
        case (i_cmd.cell_sel)
            CELL_MAIN: begin
                w_cmaj = r_major;
                w_cmin = r_minor;
            end
            CELL_PREV: begin
                w_cmaj = r_prev;
                w_cmin = r_minor;
            end
            CELL_NEXT: begin
                w_cmaj = r_major + 1'b1;
                w_cmin = r_old_minor;
            end
            default: begin
                w_cmaj = r_major;
                w_cmin = r_minor;
            end
        endcase
        w_u = r_steep ? w_cmin : w_cmaj;
        w_v = r_steep ? w_cmaj : w_cmin;
    end

    // Insert the fixed coordinate on the configured axis.
    always_comb begin
        case (r_trace_axis)
            AXIS_X: begin
                w_ka = r_axis_pos;
                w_kb = w_u;
                w_kc = w_v;
            end
            AXIS_Y: begin
                w_ka = w_u;
                w_kb = r_axis_pos;
                w_kc = w_v;
            end
            AXIS_Z: begin
                w_ka = w_u;
                w_kb = w_v;
                w_kc = r_axis_pos;
            end
            default: begin
                w_ka = '0;
                w_kb = '0;
                w_kc = '0;
            end
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_key_a <= w_ka;
            r_key_b <= w_kb;
            r_key_c <= w_kc;
            r_final <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_a      = r_key_a;
    assign o_key_b      = r_key_b;
    assign o_key_c      = r_key_c;
    assign o_final_cell = r_final;

endmodule
